/* sv/wfa_pkg.sv */
// ----------------------------------------------------------------------------
// wfa_pkg
// Shared constants and types of the worst-fit allocator core.
// ----------------------------------------------------------------------------
package wfa_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_WIDTH = 16;

	// Table index and a count that can hold MAX_BLOCKS itself.
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LIM_W = $clog2(MAX_BLOCKS + 1) + 1;

	// Fixed field widths.
	localparam int CNT_W   = 5;
	localparam int BIDX_W  = 4;
	localparam int SVAL_W  = 16;

	// Operation codes carried in s_tuser.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Register index of block_count (paddr[2]).
	localparam logic REG_BLOCK_COUNT = 1'b0;

	typedef logic [SIZE_WIDTH-1:0] size_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [LIM_W-1:0]      lim_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	// Port of the size table.
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		size_t wdata;
		logic  re;
		idx_t  raddr;
	} tbl_req_t;

endpackage

/* sv/wfa_table.sv */
// ----------------------------------------------------------------------------
// wfa_table
// Free-size table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wfa_table (
	input  logic              clk,
	input  wfa_pkg::tbl_req_t req,
	output wfa_pkg::size_t    rdata
);

	wfa_pkg::size_t mem [wfa_pkg::MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* sv/worst_fit_allocator_core.sv */
// ----------------------------------------------------------------------------
// worst_fit_allocator_core
// Worst-fit allocator over a table of free-block sizes.
// ----------------------------------------------------------------------------
// A load beat is taken while the core is idle and gives no result.
// An allocate beat starts a scan over limit = min(block_count, MAX_BLOCKS) blocks: one table
// read per block, the registered read data compared into the best pick, a state that sees the
// scan drained and waits for the result register to be free, then the write-back of the pick.
// The input is ready again as the result appears, so no new beat is taken during a scan.
// Reset clears control state and block_count; the table is not cleared.
module worst_fit_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [3:0] block_index, [19:4] size_value, [23:20] zero
	input  logic [0:0]  s_tuser,  // [0] operation
	input  logic        s_tlast,  // final_request
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [3:0] chosen_block, [7:4] zero
	output logic [0:0]  m_tuser,  // [0] found
	output logic        m_tlast,  // batch_end
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	wfa_pkg::state_t             state_q;
	logic [wfa_pkg::CNT_W-1:0]   block_count_q;
	wfa_pkg::lim_t               limit_q;
	wfa_pkg::lim_t               issue_q;
	wfa_pkg::size_t              req_q;
	logic                        last_q;
	logic                        have_q;
	wfa_pkg::idx_t               best_q;
	wfa_pkg::size_t              best_size_q;
	logic                        vld_s1;
	wfa_pkg::idx_t               idx_s1;

	logic                        out_vld_q;
	logic                        out_found_q;
	wfa_pkg::idx_t               out_idx_q;
	logic                        out_last_q;

	wfa_pkg::tbl_req_t           tbl_req;
	wfa_pkg::size_t              rdata;

	logic                        in_beat;
	logic                        out_free;
	logic                        rd_en;
	logic                        finish;
	logic [wfa_pkg::BIDX_W-1:0]  in_idx;
	wfa_pkg::size_t              in_size;
	logic                        load_ok;
	wfa_pkg::lim_t               limit_d;
	logic                        cfg_wr;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == wfa_pkg::REG_BLOCK_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
		end else if (cfg_wr) begin
			block_count_q <= pwdata[wfa_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == wfa_pkg::REG_BLOCK_COUNT) begin
			prdata = 32'(block_count_q);
		end
	end

	// ---------------- input decode ----------------
	assign s_tready = (state_q == wfa_pkg::S_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign in_idx   = s_tdata[wfa_pkg::BIDX_W-1:0];
	assign in_size  = wfa_pkg::SIZE_WIDTH'(32'(s_tdata[wfa_pkg::BIDX_W +: wfa_pkg::SVAL_W]));
	assign load_ok  = (32'(in_idx) < wfa_pkg::MAX_BLOCKS);
	assign limit_d  = (32'(block_count_q) > wfa_pkg::MAX_BLOCKS) ?
		wfa_pkg::LIM_W'(wfa_pkg::MAX_BLOCKS) : wfa_pkg::LIM_W'(block_count_q);

	assign out_free = !out_vld_q || m_tready;
	assign rd_en    = (state_q == wfa_pkg::S_SCAN) && (issue_q < limit_q);
	assign finish   = (state_q == wfa_pkg::S_FINISH) && out_free;

	// ---------------- table port ----------------
	always_comb begin
		tbl_req.re    = rd_en;
		tbl_req.raddr = issue_q[wfa_pkg::IDX_W-1:0];
		if (state_q == wfa_pkg::S_FINISH) begin
			tbl_req.we    = finish && have_q;
			tbl_req.waddr = best_q;
			tbl_req.wdata = best_size_q - req_q;
		end else begin
			tbl_req.we    = in_beat && (s_tuser[0] == wfa_pkg::OP_LOAD) && load_ok;
			tbl_req.waddr = wfa_pkg::IDX_W'(in_idx);
			tbl_req.wdata = in_size;
		end
	end

	wfa_table u_table (
		.clk   (clk),
		.req   (tbl_req),
		.rdata (rdata)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfa_pkg::S_IDLE;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			case (state_q)
				wfa_pkg::S_IDLE: begin
					if (in_beat && (s_tuser[0] == wfa_pkg::OP_ALLOC)) begin
						issue_q <= '0;
						have_q  <= 1'b0;
						state_q <= wfa_pkg::S_SCAN;
					end
				end
				wfa_pkg::S_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					// A block qualifies when it covers the request; only a strictly
					// larger size replaces the current pick, so the lowest index wins ties.
					if (vld_s1 && (rdata >= req_q) && (!have_q || (rdata > best_size_q))) begin
						have_q <= 1'b1;
					end
					if (!rd_en && !vld_s1) begin
						state_q <= wfa_pkg::S_FINISH;
					end
				end
				wfa_pkg::S_FINISH: begin
					if (out_free) begin
						state_q <= wfa_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= wfa_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && (s_tuser[0] == wfa_pkg::OP_ALLOC)) begin
			req_q   <= in_size;
			last_q  <= s_tlast;
			limit_q <= limit_d;
		end
		if (vld_s1 && (rdata >= req_q) && (!have_q || (rdata > best_size_q))) begin
			best_q      <= idx_s1;
			best_size_q <= rdata;
		end
		idx_s1 <= issue_q[wfa_pkg::IDX_W-1:0];
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_found_q <= have_q;
			out_idx_q   <= have_q ? best_q : '0;
			out_last_q  <= last_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = 8'(out_idx_q);
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

endmodule

/* sv/wfa_checker.sv */
// ----------------------------------------------------------------------------
// wfa_checker
// Port-level checks of the worst-fit allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module wfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result beat stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// An allocate beat occupies the core; the next beat must wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == wfa_pkg::OP_ALLOC) |=> !s_tready)
		else $error("input taken during an allocate scan");

	// A load finishes in its own cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == wfa_pkg::OP_LOAD) |=> s_tready)
		else $error("load stalled the input");

	// A failed request reports block zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[3:0] == 4'd0))
		else $error("chosen_block nonzero without found");

endmodule

bind worst_fit_allocator_core wfa_checker u_wfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* sim/tb_worst_fit_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worst_fit_allocator_core
// Self-checking bench for the worst-fit allocator core. A table-driven opening
// sequence covers the corner cases, then randomized phases reload block sizes
// and issue allocation requests under changing block counts and flow-control
// patterns. Every result beat is checked against a cycle-free worst-fit model or a pinned plan value.
// ----------------------------------------------------------------------------
module tb_worst_fit_allocator_core;

	localparam int SETTLE_CYC = 30;   // well beyond one full 16-block scan
	localparam int PHASES     = 16;
	localparam int PHASE_BEATS = 40;
	localparam logic [2:0] ADDR_COUNT = {wfa_pkg::REG_BLOCK_COUNT, 2'b00};
	localparam logic [2:0] ADDR_SPARE = 3'd4;
	localparam wfa_pkg::size_t TIE_SIZE = 16'h4000;

	typedef struct packed {
		logic             found;
		logic [wfa_pkg::BIDX_W-1:0] chosen;
		logic             batch_end;
	} grant_t;

	typedef struct packed {
		logic        cfg;
		logic [2:0]  addr;
		logic [31:0] wval;
		logic        op;
		logic [3:0]  idx;
		logic [15:0] size;
		logic        last;
		logic        pinned;
		logic        e_found;
		logic [3:0]  e_chosen;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [3:0] block_index, [19:4] size_value, [23:20] zero
	logic [0:0]  s_tuser;   // [0] operation
	logic        s_tlast;   // final_request
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [3:0] chosen_block, [7:4] zero
	logic [0:0]  m_tuser;   // [0] found
	logic        m_tlast;   // batch_end
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	worst_fit_allocator_core DUT (.*);

	// Model state.
	wfa_pkg::size_t             sizes_left [wfa_pkg::MAX_BLOCKS];
	logic [wfa_pkg::CNT_W-1:0]  blk_cnt;
	grant_t                     grants_due [$];

	// Expectation typed into the directed plan for the beat now on the bus.
	logic   pin_use;
	grant_t pin_res;

	int gap_pct;
	int stall_pct;
	int errors;
	int n_load, n_alloc, n_grant, n_cfg;

	step_t plan [0:29];

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= stall_pct);
	end

	function automatic grant_t worst_fit_grant(input wfa_pkg::size_t req, input logic last);
		grant_t g;
		int     lim;
		int     best;
		logic   have;
		lim  = (blk_cnt > wfa_pkg::MAX_BLOCKS) ? wfa_pkg::MAX_BLOCKS : int'(blk_cnt);
		best = 0;
		have = 1'b0;
		for (int j = 0; j < lim; j++) begin
			if (sizes_left[j] >= req && (!have || sizes_left[j] > sizes_left[best])) begin
				best = j;
				have = 1'b1;
			end
		end
		if (have)
			sizes_left[best] = sizes_left[best] - req;
		g.found     = have;
		g.chosen    = have ? best[wfa_pkg::BIDX_W-1:0] : '0;
		g.batch_end = last;
		return g;
	endfunction

	// Tracks accepted beats and register writes, and checks every result beat.
	always @(posedge clk) begin
		grant_t g;
		grant_t e;
		if (arst_n === 1'b1) begin
			if (psel && penable && pwrite && pready && paddr == ADDR_COUNT) begin
				blk_cnt = pwdata[wfa_pkg::CNT_W-1:0];
				n_cfg++;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == wfa_pkg::OP_ALLOC) begin
					g = worst_fit_grant(s_tdata[19:4], s_tlast);
					grants_due.push_back(pin_use ? pin_res : g);
					n_alloc++;
				end else begin
					sizes_left[s_tdata[3:0]] = s_tdata[19:4];
					n_load++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (grants_due.size() == 0) begin
					$display("%0t: result beat with nothing pending (tdata %h tuser %b tlast %b)",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					e = grants_due.pop_front();
					if (e.found)
						n_grant++;
					if (m_tuser[0] !== e.found) begin
						$display("%0t: found expected %b, got %b", $time, e.found, m_tuser[0]);
						errors++;
					end
					if (m_tdata !== {4'b0, e.chosen}) begin
						$display("%0t: chosen_block expected %0d, got tdata %h",
							$time, e.chosen, m_tdata);
						errors++;
					end
					if (m_tlast !== e.batch_end) begin
						$display("%0t: batch_end expected %b, got %b",
							$time, e.batch_end, m_tlast);
						errors++;
					end
				end
			end
		end
	end

	task automatic send_beat(input logic op, input wfa_pkg::idx_t idx, input wfa_pkg::size_t sz,
		input logic last, input logic pinned, input grant_t pres);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = 24'($urandom);
			s_tuser  = 1'($urandom);
			s_tlast  = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {4'b0, sz, idx};
		s_tlast  = last;
		pin_use  = pinned;
		pin_res  = pres;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	// Holds the input idle until every pending result is out, then lets the
	// core finish any load still in flight.
	task automatic drain(input int settle);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
		logic [31:0] rd;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		if (addr == ADDR_COUNT) begin
			@(negedge clk);
			penable = 1'b1;
			do @(posedge clk); while (!pready);
			rd = prdata;
			if (rd !== {{(32-wfa_pkg::CNT_W){1'b0}}, val[wfa_pkg::CNT_W-1:0]}) begin
				$display("%0t: block_count read expected %0d, got %0d",
					$time, val[wfa_pkg::CNT_W-1:0], rd);
				errors++;
			end
			@(negedge clk);
			penable = 1'b0;
		end
		psel = 1'b0;
	endtask

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still pending", grants_due.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int             cnt;
		int             nload;
		int             r;
		logic           op;
		logic           last;
		wfa_pkg::idx_t  idx;
		wfa_pkg::size_t sz;
		grant_t         pres;
		int             cnt_list [8];

		cnt_list = '{16, 31, 0, 1, 17, 15, 8, 2};

		// cfg, addr, wval, op, idx, size, last, pinned, e_found, e_chosen
		plan = '{
			// Block count is zero after reset, so nothing can be granted.
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'd5, 1'b1, 1'b1, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd0, 16'd100, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd2, 16'd0, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd3, 16'hFFFF, 1'b0, 1'b0, 1'b0, 4'd0},
			// A final mark on a load must not produce a result.
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd4, 16'd7, 1'b1, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd5, 16'd1000, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd6, 16'd1000, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd7, 16'd40000, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd8, 16'd1, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd9, 16'd12345, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd10, 16'd500, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd11, 16'hFFFE, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd12, 16'd2, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd13, 16'd300, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd14, 16'd1000, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_LOAD, 4'd15, 16'h8000, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b1, ADDR_COUNT, 32'd16, wfa_pkg::OP_LOAD, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0, 4'd0},
			// Zero request: the tie at full size goes to the lower index and
			// the block keeps its size.
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'd0, 1'b0, 1'b1, 1'b1, 4'd1},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'hFFFF, 1'b0, 1'b1, 1'b1, 4'd1},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 4'd3},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0, 4'd0},
			// A count above the table size scans the whole table.
			'{1'b1, ADDR_COUNT, 32'd31, wfa_pkg::OP_LOAD, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'd1000, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'hFFFE, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b1, ADDR_COUNT, 32'd1, wfa_pkg::OP_LOAD, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'd200, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'd100, 1'b1, 1'b0, 1'b0, 4'd0},
			// A write outside the register map leaves block_count at one.
			'{1'b1, ADDR_SPARE, 32'd16, wfa_pkg::OP_LOAD, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0, 4'd0},
			'{1'b0, 3'd0, 32'd0, wfa_pkg::OP_ALLOC, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0, 4'd0}
		};

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		pin_use  = 1'b0;
		pin_res  = '0;
		gap_pct  = 0;
		stall_pct = 0;
		errors   = 0;
		n_load   = 0;
		n_alloc  = 0;
		n_grant  = 0;
		n_cfg    = 0;
		blk_cnt  = '0;
		for (int j = 0; j < wfa_pkg::MAX_BLOCKS; j++)
			sizes_left[j] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].cfg) begin
				drain(SETTLE_CYC);
				write_reg(plan[i].addr, plan[i].wval);
			end else begin
				pres = '{plan[i].e_found, plan[i].e_chosen, plan[i].last};
				send_beat(plan[i].op, plan[i].idx, plan[i].size, plan[i].last,
					plan[i].pinned, pres);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain(SETTLE_CYC);
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 59; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 59; end
				default: begin gap_pct = 12; stall_pct = 12; end
			endcase
			cnt = (ph < 8) ? cnt_list[ph] : int'($urandom_range(0, 31));
			write_reg(ADDR_COUNT, cnt);
			if (ph == 6)
				write_reg(ADDR_SPARE, $urandom);
			nload = $urandom_range(2, 6);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (k == PHASE_BEATS / 2 && ph % 5 == 2)
					drain(0);
				r = $urandom_range(99);
				if (k < nload || r < 15) begin
					op   = wfa_pkg::OP_LOAD;
					idx  = wfa_pkg::idx_t'($urandom_range(wfa_pkg::MAX_BLOCKS - 1));
					last = 1'($urandom_range(1));
					case ($urandom_range(4))
						0: sz = wfa_pkg::size_t'($urandom);
						1: sz = wfa_pkg::size_t'($urandom_range(15));
						2: sz = '1;
						3: sz = '0;
						default: sz = TIE_SIZE;
					endcase
				end else begin
					// Requests are drawn mostly around sizes still in the
					// table so that grants, refusals and ties all occur.
					op   = wfa_pkg::OP_ALLOC;
					idx  = wfa_pkg::idx_t'($urandom);
					last = ($urandom_range(3) == 0);
					sz   = sizes_left[$urandom_range(wfa_pkg::MAX_BLOCKS - 1)];
					case ($urandom_range(9))
						0: sz = '0;
						1: sz = '1;
						2, 3, 4: ;
						5, 6: sz = sz - wfa_pkg::size_t'($urandom_range(3));
						7: sz = sz + 1'b1;
						default: sz = wfa_pkg::size_t'($urandom);
					endcase
				end
				send_beat(op, idx, sz, last, 1'b0, '0);
			end
		end

		drain(SETTLE_CYC);
		$display("Covered %0d loads and %0d allocation requests (%0d granted, %0d refused)",
			n_load, n_alloc, n_grant, n_alloc - n_grant);
		$display("across %0d block-count writes and four flow-control patterns.", n_cfg);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
